// ----- src/http_request_header_parser_macros.svh -----
// Assertion macros used by the request header parser top level.
`ifndef HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
`ifndef ASSERT_OFF
`define HRHP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define HRHP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define HRHP_ASSERT(lbl, prop, msg)
`define HRHP_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- src/hrhp_pkg.sv -----
// Types, codes and character constants of the HTTP request header parser.
`timescale 1ns / 1ps
`default_nettype none
package hrhp_pkg;
	localparam int MAX_REQUEST_BYTES_DEF = 4096;

	typedef enum logic [1:0] {PH_LINE, PH_HDR, PH_BODY, PH_DEAD} phase_t;

	localparam logic [2:0] ST_METHOD = 3'd0;
	localparam logic [2:0] ST_GAP1 = 3'd1;
	localparam logic [2:0] ST_URL = 3'd2;
	localparam logic [2:0] ST_GAP2 = 3'd3;
	localparam logic [2:0] ST_VER = 3'd4;
	localparam logic [2:0] ST_FAIL = 3'd7;
	// Header steps reuse the same register.
	localparam logic [2:0] HS_NAME = 3'd0;
	localparam logic [2:0] HS_GAP = 3'd1;
	localparam logic [2:0] HS_VALUE = 3'd2;

	localparam logic [3:0] URL_FIRST = 4'd0;
	localparam logic [3:0] URL_PREFIX = 4'd1;
	localparam logic [3:0] URL_SEEK = 4'd2;
	localparam logic [3:0] URL_PATH = 4'd3;

	localparam logic [3:0] K_CONN = 4'b0001;
	localparam logic [3:0] K_CLEN = 4'b0010;
	localparam logic [3:0] K_HOST = 4'b0100;
	localparam logic [3:0] K_STOP = 4'b1000;
	localparam logic [3:0] K_ALL = 4'b0111;

	localparam logic [1:0] OUT_OK = 2'd0;
	localparam logic [1:0] OUT_BAD = 2'd1;
	localparam logic [1:0] OUT_EOL = 2'd2;
	localparam logic [1:0] OUT_LONG = 2'd3;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_connection;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  outcome;
		logic        keep_alive;
		logic [31:0] body_length;
		logic [11:0] url_offset;
		logic [11:0] url_length;
		logic [11:0] host_offset;
		logic [11:0] host_length;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  step;
		logic [3:0]  kpos;
		logic [3:0]  kcand;
		logic        prev_cr;
		logic [11:0] url_start;
		logic [11:0] url_span;
		logic [11:0] host_start;
		logic [11:0] host_span;
		logic [31:0] body_len;
		logic [31:0] body_seen;
		logic        keep_alive;
	} state_t;

	localparam state_t STATE_INIT = '{phase: PH_LINE, default: '0};
endpackage
`default_nettype wire

// ----- src/hrhp_step.sv -----
// Next-state and result logic for one received byte.
`timescale 1ns / 1ps
`default_nettype none
module hrhp_step
	import hrhp_pkg::*;
#(
	parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF,
	parameter int PosW = $clog2(MAX_REQUEST_BYTES + 1)
) (
	input  var state_t    state,
	input  var logic [PosW-1:0] pos,
	input  var in_item_t  item,
	output state_t        next_state,
	output logic [PosW-1:0] next_pos,
	output logic          res_valid,
	output out_item_t     res
);
	function automatic logic [7:0] lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic logic blank(input logic [7:0] c);
		return c == " " || c == 8'h09;
	endfunction

	function automatic logic [7:0] pat_get(input logic [3:0] i);
		unique case (i)
			4'd0: return "g";
			4'd1: return "e";
			4'd2: return "t";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_ver(input logic [3:0] i);
		unique case (i)
			4'd0: return "H";
			4'd1: return "T";
			4'd2: return "T";
			4'd3: return "P";
			4'd4: return "/";
			4'd5: return "1";
			4'd6: return ".";
			4'd7: return "1";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_pfx(input logic [3:0] i);
		unique case (i)
			4'd0: return "h";
			4'd1: return "t";
			4'd2: return "t";
			4'd3: return "p";
			4'd4: return ":";
			4'd5: return "/";
			4'd6: return "/";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] pat_ka(input logic [3:0] i);
		unique case (i)
			4'd0: return "k";
			4'd1: return "e";
			4'd2: return "e";
			4'd3: return "p";
			4'd4: return "-";
			4'd5: return "a";
			4'd6: return "l";
			4'd7: return "i";
			4'd8: return "v";
			4'd9: return "e";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] hdr_conn(input logic [3:0] i);
		unique case (i)
			4'd0: return "c";
			4'd1: return "o";
			4'd2: return "n";
			4'd3: return "n";
			4'd4: return "e";
			4'd5: return "c";
			4'd6: return "t";
			4'd7: return "i";
			4'd8: return "o";
			4'd9: return "n";
			4'd10: return ":";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] hdr_clen(input logic [3:0] i);
		unique case (i)
			4'd0: return "c";
			4'd1: return "o";
			4'd2: return "n";
			4'd3: return "t";
			4'd4: return "e";
			4'd5: return "n";
			4'd6: return "t";
			4'd7: return "-";
			4'd8: return "l";
			4'd9: return "e";
			4'd10: return "n";
			4'd11: return "g";
			4'd12: return "t";
			4'd13: return "h";
			4'd14: return ":";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] hdr_host(input logic [3:0] i);
		unique case (i)
			4'd0: return "h";
			4'd1: return "o";
			4'd2: return "s";
			4'd3: return "t";
			4'd4: return ":";
			default: return 8'h00;
		endcase
	endfunction

	function automatic state_t url_byte(input state_t s, input logic [7:0] c,
		input logic [11:0] at);
		state_t r;
		r = s;
		if (blank(c)) begin
			r.step = (s.kcand == URL_PATH) ? ST_GAP2 : ST_FAIL;
		end else begin
			unique case (s.kcand)
				URL_FIRST: begin
					if (c == "/") begin
						r.kcand = URL_PATH;
						r.url_start = at;
						r.url_span = 12'd1;
					end else if (lower(c) == "h") begin
						r.kcand = URL_PREFIX;
						r.kpos = 4'd1;
					end else begin
						r.step = ST_FAIL;
					end
				end
				URL_PREFIX: begin
					if (s.kpos < 4'd7 && lower(c) == pat_pfx(s.kpos)) begin
						r.kpos = s.kpos + 4'd1;
						if (s.kpos == 4'd6) r.kcand = URL_SEEK;
					end else begin
						r.step = ST_FAIL;
					end
				end
				URL_SEEK: begin
					if (c == "/") begin
						r.kcand = URL_PATH;
						r.url_start = at;
						r.url_span = 12'd1;
					end
				end
				default: r.url_span = s.url_span + 12'd1;
			endcase
		end
		return r;
	endfunction

	function automatic state_t version_byte(input state_t s, input logic [7:0] c);
		state_t r;
		r = s;
		if (s.kpos < 4'd8 && c == pat_ver(s.kpos)) r.kpos = s.kpos + 4'd1;
		else r.step = ST_FAIL;
		return r;
	endfunction

	function automatic state_t value_byte(input state_t s, input logic [7:0] c);
		state_t r;
		logic [35:0] v;
		r = s;
		v = ({4'd0, s.body_len} << 3) + ({4'd0, s.body_len} << 1) + {32'd0, c[3:0]};
		if (s.kcand[0]) begin
			if (!s.kcand[3] && s.kpos < 4'd10 && lower(c) == pat_ka(s.kpos))
				r.kpos = s.kpos + 4'd1;
			else
				r.kcand = s.kcand | K_STOP;
		end else if (s.kcand[1]) begin
			if (!s.kcand[3] && c >= "0" && c <= "9")
				r.body_len = (v[35:32] != 4'd0) ? 32'hffff_ffff : v[31:0];
			else
				r.kcand = s.kcand | K_STOP;
		end else begin
			r.host_span = s.host_span + 12'd1;
		end
		return r;
	endfunction

	state_t cur;
	state_t n;
	logic [7:0] c;
	logic [11:0] at;
	logic [31:0] seen_inc;
	logic emit;
	logic [1:0] code;
	logic [3:0] done;
	logic [3:0] cand;
	logic [7:0] lc;

	always_comb begin
		cur = item.new_connection ? STATE_INIT : state;
		next_pos = item.new_connection ? '0 : pos;
		n = cur;
		c = item.data_byte;
		lc = lower(c);
		at = 12'(pos);
		if (item.new_connection) at = 12'd0;
		seen_inc = cur.body_seen + 32'd1;
		emit = 1'b0;
		code = OUT_OK;
		done = 4'd0;
		cand = cur.kcand;
		if (cur.phase == PH_DEAD) begin
			emit = 1'b0;
		end else if (next_pos >= PosW'(MAX_REQUEST_BYTES)) begin
			emit = 1'b1;
			code = OUT_LONG;
		end else begin
			next_pos = next_pos + PosW'(1);
			if (cur.phase == PH_BODY) begin
				n.body_seen = seen_inc;
				if (seen_inc >= cur.body_len) emit = 1'b1;
			end else if (cur.prev_cr) begin
				n.prev_cr = 1'b0;
				if (c != CH_LF) begin
					emit = 1'b1;
					code = OUT_EOL;
				end else if (cur.phase == PH_LINE) begin
					if (cur.step == ST_VER && cur.kpos == 4'd8) begin
						n.phase = PH_HDR;
						n.step = HS_NAME;
						n.kpos = 4'd0;
						n.kcand = K_ALL;
					end else begin
						emit = 1'b1;
						code = OUT_BAD;
					end
				end else if (cur.step == HS_NAME && cur.kpos == 4'd0) begin
					// Blank line ends the header block.
					if (cur.body_len != 32'd0) begin
						n.phase = PH_BODY;
						n.body_seen = 32'd0;
					end else begin
						emit = 1'b1;
					end
				end else begin
					if (cur.step == HS_VALUE && cur.kcand[0] && !cur.kcand[3] &&
						cur.kpos == 4'd10)
						n.keep_alive = 1'b1;
					n.step = HS_NAME;
					n.kpos = 4'd0;
					n.kcand = K_ALL;
				end
			end else if (c == CH_CR) begin
				n.prev_cr = 1'b1;
			end else if (c == CH_LF) begin
				emit = 1'b1;
				code = OUT_EOL;
			end else if (cur.phase == PH_LINE) begin
				unique case (cur.step)
					ST_METHOD: begin
						if (blank(c))
							n.step = (cur.kpos == 4'd3) ? ST_GAP1 : ST_FAIL;
						else if (cur.kpos < 4'd3 && lc == pat_get(cur.kpos))
							n.kpos = cur.kpos + 4'd1;
						else
							n.step = ST_FAIL;
					end
					ST_GAP1: begin
						if (!blank(c)) begin
							n.step = ST_URL;
							n.kcand = URL_FIRST;
							n.kpos = 4'd0;
							n = url_byte(n, c, at);
						end
					end
					ST_URL: n = url_byte(cur, c, at);
					ST_GAP2: begin
						if (!blank(c)) begin
							n.step = ST_VER;
							n.kpos = 4'd0;
							n = version_byte(n, c);
						end
					end
					ST_VER: n = version_byte(cur, c);
					default: n = cur;
				endcase
			end else begin
				unique case (cur.step)
					HS_NAME: begin
						if (cur.kcand[0]) begin
							if (cur.kpos > 4'd10 || lc != hdr_conn(cur.kpos)) cand[0] = 1'b0;
							else if (cur.kpos == 4'd10) done = K_CONN;
						end
						if (cur.kcand[1]) begin
							if (cur.kpos > 4'd14 || lc != hdr_clen(cur.kpos)) cand[1] = 1'b0;
							else if (cur.kpos == 4'd14) done = K_CLEN;
						end
						if (cur.kcand[2]) begin
							if (cur.kpos > 4'd4 || lc != hdr_host(cur.kpos)) cand[2] = 1'b0;
							else if (cur.kpos == 4'd4) done = K_HOST;
						end
						n.kcand = cand;
						if (cur.kpos < 4'd15) n.kpos = cur.kpos + 4'd1;
						if (cand == 4'd0) begin
							n.step = ST_FAIL;
						end else if (done != 4'd0) begin
							n.step = HS_GAP;
							n.kpos = 4'd0;
							n.kcand = done;
							if (done == K_HOST) begin
								n.host_start = at + 12'd1;
								n.host_span = 12'd0;
							end
							if (done == K_CLEN) n.body_len = 32'd0;
						end
					end
					HS_GAP: begin
						if (blank(c)) begin
							if (cur.kcand[2]) n.host_start = at + 12'd1;
						end else begin
							n.step = HS_VALUE;
							n = value_byte(n, c);
						end
					end
					HS_VALUE: n = value_byte(cur, c);
					default: n = cur;
				endcase
			end
		end

		res_valid = emit;
		res.outcome = code;
		if (code == OUT_OK) begin
			res.keep_alive = n.keep_alive;
			res.body_length = n.body_len;
			res.url_offset = n.url_start;
			res.url_length = n.url_span;
			res.host_offset = n.host_start;
			res.host_length = n.host_span;
		end else begin
			res.keep_alive = 1'b0;
			res.body_length = 32'd0;
			res.url_offset = 12'd0;
			res.url_length = 12'd0;
			res.host_offset = 12'd0;
			res.host_length = 12'd0;
		end

		next_state = n;
		if (emit) begin
			if (code == OUT_OK) begin
				// A finished request restarts parsing for a pipelined one.
				next_state = STATE_INIT;
				next_pos = '0;
			end else begin
				next_state.phase = PH_DEAD;
			end
		end
	end
endmodule
`default_nettype wire

// ----- src/http_request_header_parser.sv -----
// Top level of the HTTP/1.1 request header parser.
// Usage:
// The in channel carries one byte of the request stream per transfer, with
// new_connection set on the first byte of a new connection to clear all
// parse state. The out channel carries one result per request: outcome,
// keep-alive flag, Content-Length and the URL and Host spans.
// A result is registered on out after the byte that completes (or breaks)
// the request leaves the input register; most bytes give no result.
// Throughput: one byte per cycle while in_stall is low. Each byte is held
// in an input register and is parsed by one pass of byte compare and
// counter logic into the parse state and the result register.
// After an error the parser drops bytes until new_connection is set.
// Reset clears the parse state and empties both registers.
// When the receiver stalls with a result pending, the input register holds
// its byte and in_stall rises, so no byte and no result is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "http_request_header_parser_macros.svh"
module http_request_header_parser
	import hrhp_pkg::*;
#(
	parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
) (
	input  var logic      clk,
	input  var logic      arst_n,
	input  var logic      in_valid,
	output logic          in_stall,
	input  var in_item_t  in_item,
	output logic          out_valid,
	input  var logic      out_stall,
	output out_item_t     out_item
);
	localparam int PosW = $clog2(MAX_REQUEST_BYTES + 1);

	logic            valid_s1;
	in_item_t        item_s1;
	state_t          state_q;
	logic [PosW-1:0] pos_q;
	logic            out_valid_q;
	out_item_t       out_q;

	state_t          next_state;
	logic [PosW-1:0] next_pos;
	logic            res_valid;
	out_item_t       res;
	logic            advance;
	logic            proc;

	assign advance = !out_valid_q || !out_stall;
	assign proc = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	hrhp_step #(
		.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES),
		.PosW(PosW)
	) u_step (
		.state(state_q),
		.pos(pos_q),
		.item(item_s1),
		.next_state(next_state),
		.next_pos(next_pos),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q <= STATE_INIT;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (proc) begin
				state_q <= next_state;
				pos_q <= next_pos;
			end
			if (advance) out_valid_q <= proc && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_item;
		if (proc && res_valid) out_q <= res;
	end

	`HRHP_ASSERT(a_err_fields_zero, out_valid_q && out_q.outcome != OUT_OK |-> out_q.body_length == 32'd0 && !out_q.keep_alive && out_q.url_length == 12'd0, "error result carries nonzero fields")
	`HRHP_ASSERT_NEVER(a_dead_silent, proc && state_q.phase == PH_DEAD && !item_s1.new_connection && res_valid, "result produced after an error")
	`HRHP_ASSERT_NEVER(a_pos_limit, pos_q > PosW'(MAX_REQUEST_BYTES), "byte position beyond request limit")
	`HRHP_ASSERT(a_stall_holds, in_stall |=> valid_s1 && $stable(item_s1), "held input byte changed")
endmodule
`default_nettype wire
